@@ hw/rtl/prs80_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs80_pkg
// Shared types, constants and round functions of the PRESENT-80 encrypt unit.
// ----------------------------------------------------------------------------
package prs80_pkg;

  localparam int BLOCK_W     = 64;
  localparam int KEY_W       = 80;
  localparam int KEY_LOW_W   = 64;
  localparam int KEY_HIGH_W  = 16;
  localparam int RC_W        = 5;   // round counter width, holds up to 31
  localparam int ROUNDS_DEF  = 31;
  localparam int CFG_IDX_W   = 1;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [RC_W-1:0]    rc_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW  = 1'b0,
    CFG_KEY_HIGH = 1'b1
  } cfg_reg_t;

  localparam logic [KEY_LOW_W-1:0]  KEY_LOW_RST  = '1;
  localparam logic [KEY_HIGH_W-1:0] KEY_HIGH_RST = '1;

  function automatic logic [3:0] sbox(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'hC;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hB;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'hA;
      4'h7: y = 4'hD;
      4'h8: y = 4'h3;
      4'h9: y = 4'hE;
      4'hA: y = 4'hF;
      4'hB: y = 4'h8;
      4'hC: y = 4'h4;
      4'hD: y = 4'h7;
      4'hE: y = 4'h1;
      default: y = 4'h2;
    endcase
    return y;
  endfunction

  // bit i goes to bit 16*i mod 63, bit 63 stays
  function automatic block_t perm_layer(input block_t s);
    block_t r;
    r = '0;
    for (int i = 0; i < BLOCK_W; i++) begin
      if (i == BLOCK_W - 1) begin
        r[i] = s[i];
      end else begin
        r[(16 * i) % (BLOCK_W - 1)] = s[i];
      end
    end
    return r;
  endfunction

  function automatic block_t sub_layer(input block_t s);
    block_t r;
    for (int n = 0; n < BLOCK_W / 4; n++) begin
      r[4*n +: 4] = sbox(s[4*n +: 4]);
    end
    return r;
  endfunction

  // round key is the top 64 bits of the key register
  function automatic block_t round_key(input key_t k);
    return k[KEY_W-1 -: BLOCK_W];
  endfunction

  function automatic block_t round_fn(input block_t s, input key_t k);
    return perm_layer(sub_layer(s ^ round_key(k)));
  endfunction

  // rotate left by 61, S-box on top nibble, round counter into bits 19..15
  function automatic key_t key_update(input key_t k, input rc_t rc);
    key_t r;
    r = {k[18:0], k[KEY_W-1:19]};
    r[KEY_W-1 -: 4] = sbox(r[KEY_W-1 -: 4]);
    r[19:15] = r[19:15] ^ rc;
    return r;
  endfunction

endpackage

@@ hw/rtl/present80_block_encrypt_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// present80_block_encrypt_unit
// Fully unrolled PRESENT-80 encryption pipeline, one round per stage.
// ----------------------------------------------------------------------------
// Takes one 64-bit plaintext item per cycle and returns its ciphertext
// once it has passed through every stage of the pipeline: one input
// register stage, then one register stage per round, the last stage also
// doing the final key addition. Throughput is one item per clock as long as
// the consumer takes results; each stage carries its own valid bit and the
// 80-bit key alongside the data, so the key schedule runs in step with the
// rounds. Stages advance independently, so bubbles collapse and the input
// keeps accepting items while a finished result waits, until every stage is
// full. The key is written through the configuration port (index 0: key bits
// 63..0, index 1: key bits 79..64 from data bits 15..0) and resets to all
// ones. Keys are sampled at input, so write them only while the pipeline is
// empty. cfg_ready is always high.
// ----------------------------------------------------------------------------
module present80_block_encrypt_unit
  import prs80_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEF   // 1..31
) (
  input  logic                 clk,
  input  logic                 rst,
  // plaintext item channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BLOCK_W-1:0]   plaintext,
  // ciphertext item channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BLOCK_W-1:0]   ciphertext,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BLOCK_W-1:0]   cfg_data
);

  // key registers
  logic [KEY_LOW_W-1:0]  key_low;
  logic [KEY_HIGH_W-1:0] key_high;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= KEY_LOW_RST;
      key_high <= KEY_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY_LOW:  key_low  <= cfg_data;
        CFG_KEY_HIGH: key_high <= cfg_data[KEY_HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline: stage 0 holds the input item, stage r holds the state after
  // round r and the key after its r-th update. Stage ROUNDS holds ciphertext.
  logic [ROUNDS:0] vld;
  logic [ROUNDS:0] rdy;
  block_t          st  [0:ROUNDS];
  key_t            key [0:ROUNDS];

  // a stage may load when it is empty or its item moves on this cycle
  assign rdy[ROUNDS] = !vld[ROUNDS] || out_ready;

  genvar r;
  generate
    for (r = 0; r < ROUNDS; r++) begin : g_rdy
      assign rdy[r] = !vld[r] || rdy[r+1];
    end
  endgenerate

  assign in_ready = rdy[0];

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      st[0]  <= plaintext;
      key[0] <= {key_high, key_low};
    end
  end

  // round stages
  generate
    for (r = 1; r <= ROUNDS; r++) begin : g_round
      block_t st_next;
      key_t   key_next;

      always_comb begin
        key_next = key_update(key[r-1], RC_W'(r));
        st_next  = round_fn(st[r-1], key[r-1]);
        if (r == ROUNDS) begin
          st_next = st_next ^ round_key(key_next);   // final whitening
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[r] <= 1'b0;
        end else if (rdy[r]) begin
          vld[r] <= vld[r-1];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[r] && vld[r-1]) begin
          st[r]  <= st_next;
          key[r] <= key_next;
        end
      end
    end
  endgenerate

  assign out_valid  = vld[ROUNDS];
  assign ciphertext = st[ROUNDS];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // input only backs up once every stage holds an item
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&vld))
    else $error("input stalled with a free pipeline stage");

  // an accepted item lands in the input stage unchanged
  a_input_capture: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (vld[0] && st[0] == $past(plaintext)))
    else $error("accepted item not captured in input stage");

  // a full input stage whose successor cannot take its item keeps it
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[0] && !rdy[0]) |=> (vld[0] && $stable(st[0])))
    else $error("stalled input stage lost its item");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PRESENT-80 encrypt pipeline.
// ----------------------------------------------------------------------------
// Plaintext items go in through the valid/ready input channel. Ciphertext
// items come back through the output channel. A scoreboard object holds its
// own copy of the 80-bit key and its own round loop. For every accepted
// plaintext it queues the expected ciphertext, and it compares each
// ciphertext that leaves the block with the oldest entry in that queue.
// The run steps through several keys. It starts with the reset key, then
// uses all zeros, all ones, a lone top bit and random keys. The high key
// register is also written with junk in the unused data bits. Keys change
// only while the pipeline is empty. Both channels idle and stall at random,
// except in one phase that keeps both sides fully busy.
// ----------------------------------------------------------------------------
module testbench;
  import prs80_pkg::*;

  localparam int NUM_ROUNDS       = ROUNDS_DEF;
  localparam int RANDOM_PER_PHASE = 57;
  localparam int PIPE_DEPTH       = NUM_ROUNDS + 1;
  // 4-bit S-box packed as 16 nibbles, entry x at bits 4x+3..4x
  localparam logic [63:0] NIB_SUB = 64'h2174_8FE3_DA09_B65C;

  // --------------------------------------------------------------------------
  // scoreboard: key copy, cipher prediction, expected ciphertext queue
  // --------------------------------------------------------------------------
  class cipher_scoreboard;
    logic [KEY_W-1:0] key;
    block_t           expected_ct[$];
    int               errors;

    function new();
      key    = {KEY_HIGH_RST, KEY_LOW_RST};
      errors = 0;
    endfunction

    // mirror a config write; the high register keeps data bits 15..0 only
    function void write_key(cfg_reg_t idx, logic [BLOCK_W-1:0] data);
      if (idx == CFG_KEY_LOW) begin
        key[KEY_LOW_W-1:0] = data;
      end else begin
        key[KEY_W-1:KEY_LOW_W] = data[KEY_HIGH_W-1:0];
      end
    endfunction

    function block_t encrypt(block_t pt);
      block_t           st;
      block_t           sub;
      block_t           moved;
      logic [KEY_W-1:0] k;
      logic [3:0]       nib;
      st = pt;
      k  = key;
      for (int r = 1; r <= NUM_ROUNDS; r++) begin
        st = st ^ k[KEY_W-1:KEY_W-BLOCK_W];
        for (int n = 0; n < 16; n++) begin
          nib = st[4*n +: 4];
          sub[4*n +: 4] = NIB_SUB[4*nib +: 4];
        end
        // bit i lands on 16*i mod 63, the MSB stays put
        moved     = '0;
        moved[63] = sub[63];
        for (int i = 0; i < 63; i++) begin
          moved[(16 * i) % 63] = sub[i];
        end
        st = moved;
        // key schedule: rotate left 61, S-box top nibble, add round count
        k = {k[18:0], k[KEY_W-1:19]};
        nib = k[KEY_W-1 -: 4];
        k[KEY_W-1 -: 4] = NIB_SUB[4*nib +: 4];
        k[19:15] = k[19:15] ^ r[4:0];
      end
      return st ^ k[KEY_W-1:KEY_W-BLOCK_W];
    endfunction

    function void note_plaintext(block_t pt);
      expected_ct.push_back(encrypt(pt));
    endfunction

    function void check_ciphertext(block_t ct);
      block_t exp_ct;
      if (expected_ct.size() == 0) begin
        $error("ciphertext %h arrived with no plaintext outstanding", ct);
        errors++;
      end else begin
        exp_ct = expected_ct.pop_front();
        if (ct !== exp_ct) begin
          $error("ciphertext mismatch: expected %h, actual %h", exp_ct, ct);
          errors++;
        end
      end
    endfunction

    function int outstanding();
      return expected_ct.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [BLOCK_W-1:0]   plaintext;
  logic                 out_valid;
  logic                 out_ready;
  logic [BLOCK_W-1:0]   ciphertext;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BLOCK_W-1:0]   cfg_data;

  cipher_scoreboard sb;
  bit               calm;   // set: no gaps on input, no stalls on output

  present80_block_encrypt_unit #(
    .ROUNDS(NUM_ROUNDS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .plaintext (plaintext),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ciphertext(ciphertext),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the pipeline hangs. The slowest legal run is about
  // 500 items x (longest input gap + longest output stall), roughly 0.6 ms. This
  // allows several times that.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge. Inputs only move on
  // the falling edge, so the sampled values are stable here.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_key(cfg_reg_t'(cfg_index), cfg_data);
      end
      if (in_valid && in_ready) begin
        sb.note_plaintext(plaintext);
      end
      if (out_valid && out_ready) begin
        sb.check_ciphertext(ciphertext);
      end
    end
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random back-pressure, held off entirely while calm is set.
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        // occasionally start a stall; long ones are rare
        if (!calm && $urandom_range(0, 3) == 0) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 3);
        end
      end
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Input side drivers
  // --------------------------------------------------------------------------
  // Present one plaintext item and return once it is taken. When there is no
  // gap, valid stays high from the previous item and only the payload moves.
  task automatic send_block(block_t pt);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    plaintext <= pt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait until every expected ciphertext is back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [BLOCK_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // junk lands in the unused upper data bits of the high key register
  task automatic load_key(logic [KEY_W-1:0] k, logic [47:0] junk);
    write_reg(CFG_KEY_LOW, k[KEY_LOW_W-1:0]);
    write_reg(CFG_KEY_HIGH, {junk, k[KEY_W-1:KEY_LOW_W]});
  endtask

  function automatic block_t random_block();
    logic [3:0] nib;
    case ($urandom_range(0, 7))
      0: begin
        nib = 4'($urandom_range(0, 15));
        return {16{nib}};
      end
      1: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Corner plaintexts: all-zero and all-one, single end bits, alternating,
  // nibble and word patterns.
  task automatic send_corner_blocks();
    block_t corners[12];
    corners = '{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
                64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
                64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0};
    foreach (corners[i]) begin
      send_block(corners[i]);
    end
  endtask

  // One key phase: optional corner items, then random traffic, then drain.
  task automatic run_phase(bit with_corners);
    if (with_corners) begin
      send_corner_blocks();
    end
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      // now and then hold off until the pipeline has fully emptied
      if ($urandom_range(0, 39) == 0) begin
        drain();
      end
      send_block(random_block());
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb        = new();
    calm      = 1'b0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    plaintext = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_KEY_LOW;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset key (all ones) first, no writes yet
    run_phase(1'b1);

    // all-zero key; set the unused high-register bits to make sure they drop
    load_key('0, '1);
    run_phase(1'b1);

    load_key(KEY_W'({$urandom(), $urandom(), $urandom()}), 48'({$urandom(), $urandom()}));
    run_phase(1'b0);

    load_key('1, '0);
    run_phase(1'b0);

    // only the top key bit set
    load_key({1'b1, {(KEY_W-1){1'b0}}}, 48'({$urandom(), $urandom()}));
    run_phase(1'b0);

    load_key(KEY_W'({$urandom(), $urandom(), $urandom()}), 48'({$urandom(), $urandom()}));
    run_phase(1'b0);

    // full rate both ways with a fresh key
    calm = 1'b1;
    load_key(KEY_W'({$urandom(), $urandom(), $urandom()}), 48'({$urandom(), $urandom()}));
    run_phase(1'b0);

    // trailing cycles in case a stray result follows the last expected one
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/prs80_pkg.sv
hw/rtl/present80_block_encrypt_unit.sv
dv/testbench.sv
